@@ rtl/ptla_pkg.sv @@
package ptla_pkg;

  localparam int TemplateFields = 4;
  localparam int CoefBits       = 32;
  localparam int TmplBits       = 32;
  localparam int CountBits      = 16;
  localparam int SumBits        = 48;
  localparam int CfgIdxBits     = 3;
  localparam int CfgDataBits    = 32;
  localparam int ActiveBits     = 3;
  localparam int Ln2Q16         = 45426;
  localparam int FracBits       = 16;

  localparam int DefNumComponents = 4;
  localparam int DefCountBits     = 16;

  localparam logic [CoefBits-1:0]   CoefReset   = 32'h0001_0000;
  localparam logic [ActiveBits-1:0] ActiveReset = 3'd4;

  localparam logic [CfgIdxBits-1:0] RegCoef0  = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegCoef3  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegActive = 3'd4;

  typedef struct packed {
    logic [CountBits-1:0] observed_count;
    logic [TmplBits-1:0]  template_0;
    logic [TmplBits-1:0]  template_1;
    logic [TmplBits-1:0]  template_2;
    logic [TmplBits-1:0]  template_3;
    logic                 last_bin;
  } in_t;

  typedef struct packed {
    logic signed [SumBits-1:0] log_likelihood_sum;
    logic                      overflow;
  } out_t;

  function automatic logic [15:0] ln_tab(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:  v = 16'd0;
      5'd1:  v = 16'd3973;
      5'd2:  v = 16'd7719;
      5'd3:  v = 16'd11262;
      5'd4:  v = 16'd14624;
      5'd5:  v = 16'd17821;
      5'd6:  v = 16'd20870;
      5'd7:  v = 16'd23783;
      5'd8:  v = 16'd26573;
      5'd9:  v = 16'd29248;
      5'd10: v = 16'd31818;
      5'd11: v = 16'd34292;
      5'd12: v = 16'd36675;
      5'd13: v = 16'd38975;
      5'd14: v = 16'd41196;
      5'd15: v = 16'd43345;
      5'd16: v = 16'd45426;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/ptla_lane.sv @@
module ptla_lane import ptla_pkg::*; (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic                         active_i,
  input  logic signed [CoefBits-1:0]   coef_i,
  input  logic        [TmplBits-1:0]   tmpl_i,
  output logic signed [CoefBits+TmplBits-1:0] prod_o
);

  logic signed [CoefBits+TmplBits:0]   full;
  logic signed [CoefBits+TmplBits-1:0] prod_q;

  assign full = coef_i * $signed({1'b0, tmpl_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= active_i ? full[CoefBits+TmplBits-1:0] : '0;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/ptla_ln.sv @@
module ptla_ln import ptla_pkg::*; #(
  parameter int W   = 50,
  parameter int LNW = 23
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W-1:0]   x_i,
  output logic [LNW-1:0] ln_o
);

  localparam int PW = (W > 1) ? $clog2(W) : 1;

  logic [PW-1:0]     p;
  logic [W-1:0]      xa_q;
  logic [PW-1:0]     pa_q;
  logic [W+15:0]     y;
  logic [15:0]       f;
  logic [LNW-1:0]    base_q;
  logic [11:0]       delta_q;
  logic [11:0]       r_q;
  logic [23:0]       interp;
  logic [LNW-1:0]    ln_q;

  always_comb begin
    p = '0;
    for (int i = 0; i < W; i++) begin
      if (x_i[i]) p = PW'(i);
    end
  end

  assign y      = {xa_q, 16'b0} >> pa_q;
  assign f      = y[15:0];
  assign interp = delta_q * r_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q    <= x_i;
      pa_q    <= p;
      base_q  <= LNW'(pa_q) * LNW'(Ln2Q16) + LNW'(ln_tab({1'b0, f[15:12]}));
      delta_q <= 12'(ln_tab({1'b0, f[15:12]} + 5'd1) - ln_tab({1'b0, f[15:12]}));
      r_q     <= f[11:0];
      ln_q    <= base_q + LNW'(interp[23:12]);
    end
  end

  assign ln_o = ln_q;

endmodule

@@ rtl/poisson_template_loglik_accum_top.sv @@
// Channel | Signals                               | Payload
// in      | in_valid_i / in_ready_o / in_data_i   | in_t: count, templates, last_bin
// out     | out_valid_o / out_ready_i / out_data_o | out_t: sum, overflow
// cfg     | cfg_we_i / cfg_idx_i / cfg_data_i      | coef_0..3, active_components
// One bin per cycle unless stalled; results register as the last bin leaves v6.
// Seven stages: lane multiply, merge, three log stages, count multiply, accumulate.
// Reset clears valids, accumulator, overflow flag and registers to defaults.
// The pipeline stalls only when a result is due while the output still holds one.
module poisson_template_loglik_accum_top import ptla_pkg::*; #(
  parameter int NUM_COMPONENTS = DefNumComponents,
  parameter int COUNT_BITS     = DefCountBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_t                    in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_t                   out_data_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  localparam int Lanes = (NUM_COMPONENTS < TemplateFields) ? NUM_COMPONENTS : TemplateFields;
  localparam int NB    = (COUNT_BITS < CountBits) ? COUNT_BITS : CountBits;
  localparam int PB    = CoefBits + TmplBits;
  localparam int MW    = PB - FracBits + $clog2(Lanes) + 1;
  localparam int LnmW  = $clog2(MW * Ln2Q16 + 1) + 1;
  localparam int LnnW  = $clog2((NB + 1) * Ln2Q16 + 1) + 1;
  localparam int DW    = ((LnmW > LnnW) ? LnmW : LnnW) + 2;
  localparam int XW    = NB + 1 + DW;
  localparam int SW    = 64;

  localparam logic signed [SW-1:0] SumMax = {{(SW-SumBits+1){1'b0}}, {(SumBits-1){1'b1}}};
  localparam logic signed [SW-1:0] SumMin = {{(SW-SumBits+1){1'b1}}, {(SumBits-1){1'b0}}};

  logic signed [CoefBits-1:0]  coef_q [Lanes];
  logic [ActiveBits-1:0]       active_q;
  logic [ActiveBits-1:0]       limit;
  logic [TmplBits-1:0]         tmpl [TemplateFields];
  logic signed [PB-1:0]        prod [Lanes];

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic l1_q, l2_q, l3_q, l4_q, l5_q, l6_q;
  logic [NB-1:0] n1_q, n2_q, n3_q, n4_q, n5_q, n6_q;
  logic signed [MW-1:0] model_d;
  logic [MW-2:0] m2_q, m3_q, m4_q, m5_q, m6_q;
  logic [LnmW-2:0] lnm;
  logic [LnnW-2:0] lnn;
  logic signed [DW-1:0] diff;
  logic signed [XW-1:0] x_d, x6_q;
  logic signed [SW-1:0] term, sum;
  logic signed [SumBits-1:0] acc_q;
  logic ovf_q, clamp;
  logic signed [SumBits-1:0] sat;
  out_t out_q;
  logic out_valid_q;

  assign en = !(v6_q && l6_q && out_valid_q && !out_ready_i);
  assign in_ready_o = en;
  assign limit = (active_q > ActiveBits'(Lanes)) ? ActiveBits'(Lanes) : active_q;

  assign tmpl[0] = in_data_i.template_0;
  assign tmpl[1] = in_data_i.template_1;
  assign tmpl[2] = in_data_i.template_2;
  assign tmpl[3] = in_data_i.template_3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Lanes; k++) coef_q[k] <= CoefReset;
      active_q <= ActiveReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i <= RegCoef3) begin
        for (int k = 0; k < Lanes; k++) begin
          if (cfg_idx_i - RegCoef0 == CfgIdxBits'(k)) coef_q[k] <= cfg_data_i;
        end
      end else if (cfg_idx_i == RegActive) begin
        active_q <= cfg_data_i[ActiveBits-1:0];
      end
    end
  end

  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    ptla_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .active_i (ActiveBits'(k) < limit),
      .coef_i   (coef_q[k]),
      .tmpl_i   (tmpl[k]),
      .prod_o   (prod[k])
    );
  end

  always_comb begin
    model_d = '0;
    for (int k = 0; k < Lanes; k++) begin
      model_d = model_d + MW'($signed(prod[k][PB-1:FracBits]));
    end
    if (model_d < MW'(1)) model_d = MW'(1);
  end

  ptla_ln #(.W(MW-1), .LNW(LnmW-1)) u_ln_model (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (m2_q),
    .ln_o  (lnm)
  );

  ptla_ln #(.W(NB), .LNW(LnnW-1)) u_ln_count (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (n2_q),
    .ln_o  (lnn)
  );

  assign diff = DW'($signed({1'b0, lnm})) - DW'(16 * Ln2Q16) - DW'($signed({1'b0, lnn}));
  assign x_d  = XW'($signed({1'b0, n5_q})) * XW'(diff);

  assign term = (n6_q == '0) ? -SW'($signed({1'b0, m6_q}))
              : -SW'($signed({1'b0, m6_q})) + SW'(x6_q)
                + SW'($signed({1'b0, n6_q, 16'b0}));
  assign sum  = SW'(acc_q) + term;

  always_comb begin
    clamp = 1'b0;
    sat   = sum[SumBits-1:0];
    if (sum > SumMax) begin
      clamp = 1'b1;
      sat   = SumMax[SumBits-1:0];
    end else if (sum < SumMin) begin
      clamp = 1'b1;
      sat   = SumMin[SumBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l1_q <= in_data_i.last_bin;
      n1_q <= in_data_i.observed_count[NB-1:0];
      l2_q <= l1_q;  n2_q <= n1_q;  m2_q <= model_d[MW-2:0];
      l3_q <= l2_q;  n3_q <= n2_q;  m3_q <= m2_q;
      l4_q <= l3_q;  n4_q <= n3_q;  m4_q <= m3_q;
      l5_q <= l4_q;  n5_q <= n4_q;  m5_q <= m4_q;
      l6_q <= l5_q;  n6_q <= n5_q;  m6_q <= m5_q;
      x6_q <= x_d;
    end
    if (en && v6_q && l6_q) begin
      out_q.log_likelihood_sum <= sat;
      out_q.overflow           <= ovf_q | clamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q} <= '0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;
      if (en) begin
        v1_q <= in_valid_i;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        v5_q <= v4_q;
        v6_q <= v5_q;
        if (v6_q) begin
          if (l6_q) begin
            acc_q       <= '0;
            ovf_q       <= 1'b0;
            out_valid_q <= 1'b1;
          end else begin
            acc_q <= sat;
            ovf_q <= ovf_q | clamp;
          end
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/ptla_checker.sv @@
module ptla_checker import ptla_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  a_stall_needs_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> !out_ready_i)
    else $error("input stalled while output drains");

endmodule

bind poisson_template_loglik_accum_top ptla_checker u_ptla_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
